>>> src/glyph_blitter_framebuffer_macros.svh
`ifndef GLYPH_BLITTER_FRAMEBUFFER_MACROS_SVH
`define GLYPH_BLITTER_FRAMEBUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GBF_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("glyph blitter: same-cycle check failed");

// next-cycle implication
`define GBF_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("glyph blitter: next-cycle check failed");

`endif

>>> src/gbf_pkg.sv
`timescale 1ns / 1ps

package gbf_pkg;

    localparam int FB_ROWS_DEF     = 64;
    localparam int FB_COLS_DEF     = 128;
    localparam int GLYPH_COUNT_DEF = 95;
    localparam int FONT_DEPTH_DEF  = 16384;

    localparam int GBW_W      = 4;
    localparam int GH_W       = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 2'd2;

    localparam logic [GBW_W-1:0] GBW_RESET = 4'd3;
    localparam logic [GH_W-1:0]  GH_RESET  = 6'd12;

    localparam logic [7:0] CODE_FIRST = 8'd32;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DRAW = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef struct packed {
        logic [GBW_W-1:0] glyph_byte_width;
        logic [GH_W-1:0]  glyph_height;
        logic             invert_mode;
    } cfg_t;

    typedef struct packed {
        logic font_we;
        logic font_re;
        logic frame_we;
        logic frame_re;
    } mem_ctl_t;

endpackage

>>> src/gbf_ram.sv
`timescale 1ns / 1ps

module gbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/gbf_ctrl.sv
`timescale 1ns / 1ps

module gbf_ctrl #(
    parameter int FB_ROWS     = gbf_pkg::FB_ROWS_DEF,
    parameter int FB_COLS     = gbf_pkg::FB_COLS_DEF,
    parameter int GLYPH_COUNT = gbf_pkg::GLYPH_COUNT_DEF,
    parameter int FONT_DEPTH  = gbf_pkg::FONT_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  gbf_pkg::cfg_t                          cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             op,
    input  logic [13:0]                            font_address,
    input  logic [7:0]                             font_byte,
    input  logic [7:0]                             char_code,
    input  logic signed [8:0]                      x_pixel,
    input  logic signed [6:0]                      y_pixel,
    input  logic [5:0]                             string_index,
    input  logic [5:0]                             read_row,
    input  logic [6:0]                             read_col,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [7:0]                             pixel_pair,
    output gbf_pkg::mem_ctl_t                      mem_ctl,
    output logic [$clog2(FONT_DEPTH)-1:0]          font_waddr,
    output logic [7:0]                             font_wdata,
    output logic [$clog2(FONT_DEPTH)-1:0]          font_raddr,
    input  logic [7:0]                             font_rdata,
    output logic [$clog2(FB_ROWS*FB_COLS)-1:0]     frame_waddr,
    output logic [7:0]                             frame_wdata,
    output logic [$clog2(FB_ROWS*FB_COLS)-1:0]     frame_raddr,
    input  logic [7:0]                             frame_rdata
);

    import gbf_pkg::*;

    localparam int FB_DEPTH = FB_ROWS * FB_COLS;
    localparam int FB_AW    = $clog2(FB_DEPTH);
    localparam int FONT_AW  = $clog2(FONT_DEPTH);
    localparam int RBW      = $clog2(FB_ROWS);
    localparam int CBW      = $clog2(FB_COLS);
    localparam int LINE_MAX = GLYPH_COUNT * 15;
    localparam int RED_MAX0 = (LINE_MAX > 16383) ? LINE_MAX : 16383;
    localparam int RED_MAX  = (RED_MAX0 > 2 * FONT_DEPTH - 1) ? RED_MAX0 : 2 * FONT_DEPTH - 1;
    localparam int RED_W    = $clog2(RED_MAX + 1);
    localparam int RW       = 10;
    localparam int CW       = 12;

    localparam logic [RED_W-1:0]   RED_DEPTH  = RED_W'(FONT_DEPTH);
    localparam logic [FONT_AW:0]   SUM_DEPTH  = (FONT_AW+1)'(FONT_DEPTH);
    localparam logic [FB_AW-1:0]   CLR_LAST   = FB_AW'(FB_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_DRAW,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    state_t               state_reg, state_next;
    logic [FB_AW-1:0]     clr_addr_reg, clr_addr_next;
    op_t                  op_reg, op_next;
    logic [7:0]           byte_reg, byte_next;
    logic [RED_W-1:0]     red_a_reg, red_a_next;
    logic [RED_W-1:0]     red_b_reg, red_b_next;
    logic [FONT_AW-1:0]   line_mod_reg, line_mod_next;
    logic [FONT_AW-1:0]   row_base_reg, row_base_next;
    logic [GH_W-1:0]      fy_reg, fy_next;
    logic [GBW_W-1:0]     i_reg, i_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [CW-1:0]        col0_reg, col0_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [FB_AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [FB_AW-1:0]     rd_addr_reg, rd_addr_next;
    logic                 rd_zero_reg, rd_zero_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           pixel_reg, pixel_next;

    logic [7:0]           glyph;
    logic                 code_ok;
    logic [9:0]           xsum;
    logic [9:0]           xhalf;
    logic [9:0]           idx_off;
    logic                 rd_in_frame;
    logic [FONT_AW:0]     fsum;
    logic [FONT_AW:0]     rsum;
    logic [CW-1:0]        col;
    logic                 in_frame;
    logic                 a_hi;
    logic                 b_hi;

    assign glyph   = char_code - CODE_FIRST;
    assign code_ok = (char_code >= CODE_FIRST) && ({1'b0, glyph} < 9'(GLYPH_COUNT));
    assign xsum    = {x_pixel[8], x_pixel} + 10'(x_pixel[8]);
    assign xhalf   = {xsum[9], xsum[9:1]};
    assign idx_off = 10'(string_index) * 10'(cfg.glyph_byte_width);
    assign rd_in_frame = (9'(read_row) < 9'(FB_ROWS)) && (10'(read_col) < 10'(FB_COLS));

    assign fsum     = {1'b0, row_base_reg} + (FONT_AW+1)'(i_reg);
    assign rsum     = {1'b0, row_base_reg} + {1'b0, line_mod_reg};
    assign col      = col0_reg + CW'(i_reg);
    assign in_frame = !row_reg[RW-1] && (row_reg[RW-2:0] < (RW-1)'(FB_ROWS))
                   && !col[CW-1] && (col[CW-2:0] < (CW-1)'(FB_COLS));
    assign a_hi     = red_a_reg >= RED_DEPTH;
    assign b_hi     = red_b_reg >= RED_DEPTH;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        red_a_next     = red_a_reg;
        red_b_next     = red_b_reg;
        line_mod_next  = line_mod_reg;
        row_base_next  = row_base_reg;
        fy_next        = fy_reg;
        i_next         = i_reg;
        row_next       = row_reg;
        col0_next      = col0_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        rd_addr_next   = rd_addr_reg;
        rd_zero_next   = rd_zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pixel_next     = pixel_reg;

        mem_ctl     = '0;
        font_waddr  = red_a_reg[FONT_AW-1:0];
        font_wdata  = byte_reg;
        font_raddr  = (fsum >= SUM_DEPTH) ? FONT_AW'(fsum - SUM_DEPTH) : fsum[FONT_AW-1:0];
        frame_waddr = wr_addr_reg;
        frame_wdata = cfg.invert_mode ? ~font_rdata : font_rdata;
        frame_raddr = rd_addr_reg;

        // write stage of the draw: zero font bytes are transparent unless inverted
        if (wr_pend_reg && (cfg.invert_mode || (font_rdata != 8'd0)))
        begin
            mem_ctl.frame_we = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.frame_we = 1'b1;
                frame_waddr      = clr_addr_reg;
                frame_wdata      = 8'd0;
                clr_addr_next    = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(op))
                        OP_LOAD:
                        begin
                            op_next    = OP_LOAD;
                            byte_next  = font_byte;
                            red_a_next = RED_W'(font_address);
                            red_b_next = '0;
                            state_next = ST_REDUCE;
                        end
                        OP_DRAW:
                        begin
                            if (code_ok && (cfg.glyph_byte_width != '0)
                                && (cfg.glyph_height != '0))
                            begin
                                op_next    = OP_DRAW;
                                red_a_next = RED_W'(GLYPH_COUNT) * RED_W'(cfg.glyph_byte_width);
                                red_b_next = RED_W'(glyph) * RED_W'(cfg.glyph_byte_width);
                                row_next   = {{(RW-7){y_pixel[6]}}, y_pixel};
                                col0_next  = {{(CW-10){xhalf[9]}}, xhalf} + CW'(idx_off);
                                state_next = ST_REDUCE;
                            end
                        end
                        OP_READ:
                        begin
                            rd_addr_next = FB_AW'(read_row) * FB_AW'(FB_COLS)
                                         + FB_AW'(read_col);
                            rd_zero_next = !rd_in_frame;
                            state_next   = rd_in_frame ? ST_RD_ISSUE : ST_RD_DATA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REDUCE:
            begin
                // bring addresses below the font depth, one subtract a cycle
                if (a_hi)
                begin
                    red_a_next = red_a_reg - RED_DEPTH;
                end
                if (b_hi)
                begin
                    red_b_next = red_b_reg - RED_DEPTH;
                end
                if (!a_hi && !b_hi)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        mem_ctl.font_we = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        line_mod_next = red_a_reg[FONT_AW-1:0];
                        row_base_next = red_b_reg[FONT_AW-1:0];
                        fy_next       = '0;
                        i_next        = '0;
                        state_next    = ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                mem_ctl.font_re = 1'b1;
                wr_pend_next    = in_frame;
                wr_addr_next    = FB_AW'(row_reg[RBW-1:0]) * FB_AW'(FB_COLS)
                                + FB_AW'(col[CBW-1:0]);
                if (i_reg == cfg.glyph_byte_width - 1'b1)
                begin
                    i_next = '0;
                    if (fy_reg == cfg.glyph_height - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fy_next       = fy_reg + 1'b1;
                        row_next      = row_reg + 1'b1;
                        row_base_next = (rsum >= SUM_DEPTH) ? FONT_AW'(rsum - SUM_DEPTH)
                                                            : rsum[FONT_AW-1:0];
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_RD_ISSUE:
            begin
                mem_ctl.frame_re = 1'b1;
                mem_ctl.frame_we = 1'b1;
                frame_waddr      = rd_addr_reg;
                frame_wdata      = 8'd0;
                state_next       = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = rd_zero_reg ? 8'd0 : frame_rdata;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            op_reg        <= OP_LOAD;
            byte_reg      <= '0;
            red_a_reg     <= '0;
            red_b_reg     <= '0;
            line_mod_reg  <= '0;
            row_base_reg  <= '0;
            fy_reg        <= '0;
            i_reg         <= '0;
            row_reg       <= '0;
            col0_reg      <= '0;
            wr_pend_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            rd_addr_reg   <= '0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pixel_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            op_reg        <= op_next;
            byte_reg      <= byte_next;
            red_a_reg     <= red_a_next;
            red_b_reg     <= red_b_next;
            line_mod_reg  <= line_mod_next;
            row_base_reg  <= row_base_next;
            fy_reg        <= fy_next;
            i_reg         <= i_next;
            row_reg       <= row_next;
            col0_reg      <= col0_next;
            wr_pend_reg   <= wr_pend_next;
            wr_addr_reg   <= wr_addr_next;
            rd_addr_reg   <= rd_addr_next;
            rd_zero_reg   <= rd_zero_next;
            out_valid_reg <= out_valid_next;
            pixel_reg     <= pixel_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign pixel_pair = pixel_reg;

endmodule

>>> src/glyph_blitter_framebuffer.sv
// Load: the item is taken from idle; the font byte is written in the reduction state.
// Draw: address reduction, then glyph_height * glyph_byte_width font reads, one per byte;
//   a byte inside the frame is written to the frame memory unless zero and not inverted.
// Read and clear: pixel_pair is registered and held while stalled; the pixel is zeroed.
// Reset: all FB_ROWS * FB_COLS (8192) frame addresses are cleared; in_ready stays low,
//   configuration writes are taken throughout. Font memory is not cleared.
`timescale 1ns / 1ps

`include "glyph_blitter_framebuffer_macros.svh"

module glyph_blitter_framebuffer #(
    parameter int FB_ROWS     = gbf_pkg::FB_ROWS_DEF,
    parameter int FB_COLS     = gbf_pkg::FB_COLS_DEF,
    parameter int GLYPH_COUNT = gbf_pkg::GLYPH_COUNT_DEF,
    parameter int FONT_DEPTH  = gbf_pkg::FONT_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       op,
    input  logic [13:0]                      font_address,
    input  logic [7:0]                       font_byte,
    input  logic [7:0]                       char_code,
    input  logic signed [8:0]                x_pixel,
    input  logic signed [6:0]                y_pixel,
    input  logic [5:0]                       string_index,
    input  logic [5:0]                       read_row,
    input  logic [6:0]                       read_col,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       pixel_pair
);

    import gbf_pkg::*;

    localparam int FB_DEPTH = FB_ROWS * FB_COLS;
    localparam int FB_AW    = $clog2(FB_DEPTH);
    localparam int FONT_AW  = $clog2(FONT_DEPTH);

    cfg_t               cfg_reg, cfg_next;
    mem_ctl_t           mem_ctl;
    logic [FONT_AW-1:0] font_waddr;
    logic [7:0]         font_wdata;
    logic [FONT_AW-1:0] font_raddr;
    logic [7:0]         font_rdata;
    logic [FB_AW-1:0]   frame_waddr;
    logic [7:0]         frame_wdata;
    logic [FB_AW-1:0]   frame_raddr;
    logic [7:0]         frame_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_GLYPH_WIDTH:  cfg_next.glyph_byte_width = cfg_data[GBW_W-1:0];
                CFG_GLYPH_HEIGHT: cfg_next.glyph_height     = cfg_data[GH_W-1:0];
                CFG_INVERT:       cfg_next.invert_mode      = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_byte_width <= GBW_RESET;
            cfg_reg.glyph_height     <= GH_RESET;
            cfg_reg.invert_mode      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbf_ctrl #(
        .FB_ROWS     (FB_ROWS),
        .FB_COLS     (FB_COLS),
        .GLYPH_COUNT (GLYPH_COUNT),
        .FONT_DEPTH  (FONT_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .font_address (font_address),
        .font_byte    (font_byte),
        .char_code    (char_code),
        .x_pixel      (x_pixel),
        .y_pixel      (y_pixel),
        .string_index (string_index),
        .read_row     (read_row),
        .read_col     (read_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_pair   (pixel_pair),
        .mem_ctl      (mem_ctl),
        .font_waddr   (font_waddr),
        .font_wdata   (font_wdata),
        .font_raddr   (font_raddr),
        .font_rdata   (font_rdata),
        .frame_waddr  (frame_waddr),
        .frame_wdata  (frame_wdata),
        .frame_raddr  (frame_raddr),
        .frame_rdata  (frame_rdata)
    );

    gbf_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (mem_ctl.font_we),
        .waddr (font_waddr),
        .wdata (font_wdata),
        .re    (mem_ctl.font_re),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    gbf_ram #(
        .WIDTH (8),
        .DEPTH (FB_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_ctl.frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (mem_ctl.frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    // no font reads or read-and-clear cycles while an item can be taken
    `GBF_ASSERT_NOW(a_idle_no_mem_read, in_ready, !mem_ctl.font_re && !mem_ctl.frame_re)
    // a read-and-clear always writes the zero alongside the read
    `GBF_ASSERT_NOW(a_read_clears, mem_ctl.frame_re, mem_ctl.frame_we)
    // the frame read result is collected before another item is taken
    `GBF_ASSERT_NEXT(a_read_then_busy, mem_ctl.frame_re, !in_ready)
    // a load always passes through address reduction
    `GBF_ASSERT_NEXT(a_load_busy, in_valid && in_ready && (op_t'(op) == OP_LOAD), !in_ready)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import gbf_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [7:0] CODE_LAST     = 8'(int'(CODE_FIRST) + GLYPH_COUNT_DEF - 1);
    localparam int         SETTLE_CYCLES = 300;
    localparam int         LIMIT_CYCLES  = 2000000;

    typedef struct {
        logic [1:0]        op;
        logic [13:0]       font_address;
        logic [7:0]        font_byte;
        logic [7:0]        char_code;
        logic signed [8:0] x_pixel;
        logic signed [6:0] y_pixel;
        logic [5:0]        string_index;
        logic [5:0]        read_row;
        logic [6:0]        read_col;
    } blit_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            op = '0;
    logic [13:0]           font_address = '0;
    logic [7:0]            font_byte = '0;
    logic [7:0]            char_code = '0;
    logic signed [8:0]     x_pixel = '0;
    logic signed [6:0]     y_pixel = '0;
    logic [5:0]            string_index = '0;
    logic [5:0]            read_row = '0;
    logic [6:0]            read_col = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            pixel_pair;

    // frame and font images, kept in step with accepted items
    logic [7:0]  frame_img [0:FB_ROWS_DEF*FB_COLS_DEF-1];
    logic [7:0]  font_img [0:FONT_DEPTH_DEF-1];
    bit          font_known [0:FONT_DEPTH_DEF-1];
    logic [3:0]  glyph_w;
    logic [5:0]  glyph_h;
    logic        invert_on;
    logic [7:0]  expected_pixels [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int last_x = 0;
    int last_y = 0;
    int last_idx = 0;

    glyph_blitter_framebuffer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .font_address (font_address),
        .font_byte    (font_byte),
        .char_code    (char_code),
        .x_pixel      (x_pixel),
        .y_pixel      (y_pixel),
        .string_index (string_index),
        .read_row     (read_row),
        .read_col     (read_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_pair   (pixel_pair)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_pixels
        logic [7:0] want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel_pair %02h with no read pending", pixel_pair));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_pair !== want)
                begin
                    report_mismatch($sformatf("pixel_pair %02h, want %02h", pixel_pair, want));
                end
            end
        end
    end

    function automatic int font_addr(int glyph, int fy, int i);
        return (fy * GLYPH_COUNT_DEF * int'(glyph_w) + glyph * int'(glyph_w) + i)
               % FONT_DEPTH_DEF;
    endfunction

    function automatic void draw_model(logic [7:0] code, int xs, int ys, int idx);
        int w;
        int h;
        int glyph;
        int col0;
        int row;
        int col;
        logic [7:0] fb;
        w = glyph_w;
        h = glyph_h;
        if (code < CODE_FIRST || code > CODE_LAST)
            return;
        glyph = int'(code) - int'(CODE_FIRST);
        col0 = xs / 2 + idx * w;
        for (int fy = 0; fy < h; fy++)
        begin
            row = ys + fy;
            if (row < 0 || row >= FB_ROWS_DEF)
                continue;
            for (int i = 0; i < w; i++)
            begin
                col = col0 + i;
                if (col < 0 || col >= FB_COLS_DEF)
                    continue;
                fb = font_img[font_addr(glyph, fy, i)];
                if (invert_on)
                    frame_img[row * FB_COLS_DEF + col] = ~fb;
                else if (fb != 8'd0)
                    frame_img[row * FB_COLS_DEF + col] = fb;
            end
        end
    endfunction

    function automatic void apply_item(blit_item_t it);
        int row;
        int col;
        logic [7:0] pix;
        case (it.op)
            OP_LOAD:
            begin
                font_img[it.font_address] = it.font_byte;
                font_known[it.font_address] = 1'b1;
            end
            OP_DRAW:
                draw_model(it.char_code, int'(it.x_pixel), int'(it.y_pixel),
                           int'(it.string_index));
            OP_READ:
            begin
                row = it.read_row;
                col = it.read_col;
                pix = 8'd0;
                if (row < FB_ROWS_DEF && col < FB_COLS_DEF)
                begin
                    pix = frame_img[row * FB_COLS_DEF + col];
                    frame_img[row * FB_COLS_DEF + col] = 8'd0;
                end
                expected_pixels.push_back(pix);
            end
            default:
                ;
        endcase
    endfunction

    function automatic blit_item_t random_item();
        blit_item_t it;
        it.op           = 2'($urandom_range(0, 3));
        it.font_address = 14'($urandom);
        it.font_byte    = 8'($urandom);
        it.char_code    = 8'($urandom);
        it.x_pixel      = 9'($urandom);
        it.y_pixel      = 7'($urandom);
        it.string_index = 6'($urandom);
        it.read_row     = 6'($urandom);
        it.read_col     = 7'($urandom);
        return it;
    endfunction

    function automatic blit_item_t load_item(int addr, int data);
        blit_item_t it;
        it = random_item();
        it.op = OP_LOAD;
        it.font_address = addr[13:0];
        it.font_byte = data[7:0];
        return it;
    endfunction

    function automatic blit_item_t draw_item(int code, int x, int y, int idx);
        blit_item_t it;
        it = random_item();
        it.op = OP_DRAW;
        it.char_code = code[7:0];
        it.x_pixel = x[8:0];
        it.y_pixel = y[6:0];
        it.string_index = idx[5:0];
        return it;
    endfunction

    function automatic blit_item_t read_item(int row, int col);
        blit_item_t it;
        it = random_item();
        it.op = OP_READ;
        it.read_row = row[5:0];
        it.read_col = col[6:0];
        return it;
    endfunction

    function automatic int fill_byte();
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 255));
    endfunction

    function automatic int pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(32, 35);
        else if (r < 85)
            return $urandom_range(123, 126);
        else
            return $urandom_range(int'(CODE_FIRST), int'(CODE_LAST));
    endfunction

    task automatic send_item(input blit_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= it.op;
        font_address <= it.font_address;
        font_byte    <= it.font_byte;
        char_code    <= it.char_code;
        x_pixel      <= it.x_pixel;
        y_pixel      <= it.y_pixel;
        string_index <= it.string_index;
        read_row     <= it.read_row;
        read_col     <= it.read_col;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        apply_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_GLYPH_WIDTH:  glyph_w = val[GBW_W-1:0];
            CFG_GLYPH_HEIGHT: glyph_h = val[GH_W-1:0];
            CFG_INVERT:       invert_on = val[0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    // block must be idle, including a draw still running after the last result
    task automatic set_layout(int w, int h, int inv);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_GLYPH_WIDTH, 6'(w));
        write_reg(CFG_GLYPH_HEIGHT, 6'(h));
        write_reg(CFG_INVERT, 6'(inv));
    endtask

    task automatic choose_layout();
        int w;
        int h;
        case ($urandom_range(0, 5))
            0:       begin w = GBW_RESET; h = GH_RESET; end
            1:       begin w = 1; h = 1; end
            2:       begin w = 8; h = $urandom_range(1, 4); end
            3:       begin w = $urandom_range(1, 2); h = 32; end
            4:       begin w = $urandom_range(1, 8); h = $urandom_range(1, 6); end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    w = 0;
                    h = $urandom_range(1, 8);
                end
                else
                begin
                    w = $urandom_range(1, 8);
                    h = 0;
                end
            end
        endcase
        set_layout(w, h, $urandom_range(0, 1));
    endtask

    // every font byte a draw may touch is loaded first, clipped or not
    task automatic load_glyph(int code);
        int glyph;
        int a;
        if (code < int'(CODE_FIRST) || code > int'(CODE_LAST))
            return;
        glyph = code - int'(CODE_FIRST);
        for (int fy = 0; fy < int'(glyph_h); fy++)
        begin
            for (int i = 0; i < int'(glyph_w); i++)
            begin
                a = font_addr(glyph, fy, i);
                if (!font_known[a])
                    send_item(load_item(a, fill_byte()));
            end
        end
    endtask

    task automatic read_near(int row0, int col0);
        int hh;
        int ww;
        int r;
        int c;
        hh = (glyph_h == 0) ? 1 : int'(glyph_h);
        ww = (glyph_w == 0) ? 1 : int'(glyph_w);
        r = row0 + int'($urandom_range(0, hh - 1));
        c = col0 + int'($urandom_range(0, ww - 1));
        if (r < 0 || r >= FB_ROWS_DEF || c < 0 || c >= FB_COLS_DEF)
        begin
            r = $urandom_range(0, FB_ROWS_DEF - 1);
            c = $urandom_range(0, FB_COLS_DEF - 1);
        end
        send_item(read_item(r, c));
    endtask

    task automatic draw_and_read(int code, int x, int y, int idx, int n_reads);
        load_glyph(code);
        send_item(draw_item(code, x, y, idx));
        repeat (n_reads) read_near(y, x / 2 + idx * int'(glyph_w));
    endtask

    task automatic traffic_step();
        int r;
        int ww;
        int hh;
        blit_item_t it;
        r = $urandom_range(0, 99);
        ww = (glyph_w == 0) ? 1 : int'(glyph_w);
        hh = (glyph_h == 0) ? 1 : int'(glyph_h);
        if (r < 45)
        begin
            if ($urandom_range(0, 4) == 0)
                last_x = int'($urandom_range(0, 511)) - 256;
            else
                last_x = int'($urandom_range(0, 255 + 2 * ww)) - 2 * ww;
            if ($urandom_range(0, 4) == 0)
                last_y = int'($urandom_range(0, 127)) - 64;
            else
                last_y = int'($urandom_range(0, 63 + hh)) - hh;
            last_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
            draw_and_read(pick_code(), last_x, last_y, last_idx, $urandom_range(1, 4));
        end
        else if (r < 55)
        begin
            // overdraw the previous glyph box
            draw_and_read(pick_code(), last_x, last_y, last_idx, $urandom_range(1, 3));
        end
        else if (r < 70)
        begin
            send_item(read_item($urandom_range(0, 63), $urandom_range(0, 127)));
        end
        else if (r < 80)
        begin
            send_item(load_item($urandom_range(0, FONT_DEPTH_DEF - 1), fill_byte()));
        end
        else if (r < 87)
        begin
            it = random_item();
            it.op = OP_DRAW;
            it.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(127, 255));
            send_item(it);
        end
        else if (r < 94)
        begin
            it = random_item();
            it.op = OP_UNUSED;
            send_item(it);
        end
        else
        begin
            wait_results();
        end
    endtask

    task automatic test_directed();
        set_layout(1, 2, 0);
        send_item(read_item(63, 0));
        send_item(load_item(0, 8'hA5));
        send_item(load_item(95, 8'h00));
        send_item(load_item(94, 8'hFF));
        send_item(load_item(189, 8'h3C));
        send_item(load_item(FONT_DEPTH_DEF - 1, 8'h81));
        send_item(draw_item(32, 0, 0, 0));
        send_item(draw_item(126, 255, 62, 0));
        send_item(draw_item(126, -3, -1, 2));
        send_item(draw_item(126, 254, 63, 1));
        send_item(draw_item(31, 4, 4, 0));
        send_item(draw_item(127, 4, 4, 0));
        send_item(draw_item(0, 4, 4, 0));
        send_item(draw_item(255, 4, 4, 0));
        send_item(read_item(0, 0));
        send_item(read_item(1, 0));
        send_item(read_item(62, 127));
        send_item(read_item(63, 127));
        send_item(read_item(0, 1));
        send_item(read_item(0, 0));
        send_item(load_item(0, 8'h00) );
        send_item(load_item(0, 8'hA5));
        set_layout(1, 2, 1);
        send_item(draw_item(32, -1, 0, 0));
        send_item(read_item(0, 0));
        send_item(read_item(1, 0));
        set_layout(0, 2, 1);
        send_item(draw_item(32, 0, 10, 0));
        set_layout(1, 0, 1);
        send_item(draw_item(32, 0, 10, 0));
        send_item(read_item(10, 0));
    endtask

    task automatic test_traffic(int send_pct, int recv_pct, int quota);
        int start;
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            choose_layout();
            stop_at = items_sent + 65;
            while (items_sent < stop_at && items_sent - start < quota)
                traffic_step();
        end
    endtask

    // eight-byte-wide, 32-row glyph: font addresses run past the store and wrap
    task automatic test_font_wrap();
        int inv;
        inv = $urandom_range(0, 1);
        set_layout(8, 32, inv);
        draw_and_read(126, 0, 0, 0, 12);
        set_layout(8, 32, 1 - inv);
        draw_and_read(126, 1, 40, 0, 8);
    endtask

    initial
    begin : timeout
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int wait_cycles;
        for (int k = 0; k < FB_ROWS_DEF * FB_COLS_DEF; k++)
            frame_img[k] = 8'd0;
        for (int k = 0; k < FONT_DEPTH_DEF; k++)
        begin
            font_img[k] = 8'd0;
            font_known[k] = 1'b0;
        end
        glyph_w = GBW_RESET;
        glyph_h = GH_RESET;
        invert_on = 1'b0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_traffic(18, 78, 260);
        test_traffic(78, 18, 260);
        test_traffic(0, 0, 260);
        test_font_wrap();

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_pixels.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d reads never answered", expected_pixels.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/gbf_pkg.sv
src/gbf_ram.sv
src/gbf_ctrl.sv
src/glyph_blitter_framebuffer.sv
sim/tb.sv
